// File: hw/rtl/ovle_pkg.sv
// Shared types and codes for the ordered value list engine.
`default_nettype none

package ovle_pkg;

   // Requested operation codes.
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } seq_state_type;

   // Strobes from the sequencer to the entry store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   // One finished result.
   typedef struct packed {
      status_type  status;
      logic [4:0]  position;
      logic [4:0]  entry_count;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/ovle_store.sv
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module ovle_store
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire mem_ctl_type       mem_ctl,
   input  wire logic [AW-1:0]     rd_addr,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [31:0]       wr_data,
   output logic      [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ovle_seq.sv
// Sequencer: walks the entry store through one shared compare unit and shifts on delete.
`default_nettype none

module ovle_seq
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CW    = 5,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire op_type            req_op,
   input  wire logic [31:0]       req_value,
   input  wire logic              out_free,
   output logic                   res_load,
   output result_type             res,
   output mem_ctl_type            mem_ctl,
   output logic      [AW-1:0]     rd_addr,
   output logic      [AW-1:0]     wr_addr,
   output logic      [31:0]       wr_data,
   input  wire logic [31:0]       rd_data
);

   seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic          pend_ff, pend_in;
   logic          del_ff, del_in;
   logic [31:0]   key_ff, key_in;
   status_type    stat_ff, stat_in;
   logic [CW-1:0] pos_ff, pos_in;

   logic          accept;
   logic          issue;
   logic          match;
   logic          last;
   logic          full;
   logic          empty;
   logic [CW-1:0] pidx_m1;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign issue   = ((state_ff == S_SCAN) || (state_ff == S_SHIFT)) && (idx_ff < count_ff);
   assign match   = pend_ff && (rd_data == key_ff);
   assign last    = pend_ff && (pidx_ff == (count_ff - CW'(1)));
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pidx_m1 = pidx_ff - CW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req_op inside {OP_SEARCH, OP_DELETE}) && !empty) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (match && del_ff) begin
               state_in = S_SHIFT;
            end else if (match || last) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (!issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs toward the store, the request side and the result register.
   always_comb begin
      mem_ctl.rd_en = issue;
      mem_ctl.wr_en = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_addr       = pidx_m1[AW-1:0];
      wr_data       = rd_data;
      req_stall     = (state_ff != S_IDLE);
      res_load      = (state_ff == S_DONE) && out_free;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_APPEND && !full) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = count_ff[AW-1:0];
               wr_data       = req_value;
            end
         end
         S_SHIFT: begin
            mem_ctl.wr_en = pend_ff;
         end
         default: begin
         end
      endcase
   end

   assign res.status      = stat_ff;
   assign res.position    = 5'(pos_ff);
   assign res.entry_count = 5'(count_ff);

   // Datapath registers.
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      pidx_in  = pidx_ff;
      pend_in  = 1'b0;
      del_in   = del_ff;
      key_in   = key_ff;
      stat_in  = stat_ff;
      pos_in   = pos_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               key_in  = req_value;
               del_in  = (req_op == OP_DELETE);
               stat_in = STAT_NOT_FOUND;
               pos_in  = '0;
               case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        stat_in  = STAT_DONE;
                        pos_in   = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE: begin
                     if (empty) begin
                        stat_in = STAT_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            pend_in = issue;
            pidx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (match) begin
               stat_in = STAT_DONE;
               pos_in  = pidx_ff + CW'(1);
               if (del_ff) begin
                  // Start moving entries down from the one after the match.
                  idx_in  = pidx_ff + CW'(1);
                  pend_in = 1'b0;
               end
            end else if (last) begin
               stat_in = STAT_NOT_FOUND;
               pos_in  = '0;
            end
         end
         S_SHIFT: begin
            pend_in = issue;
            pidx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pidx_ff <= pidx_in;
      del_ff  <= del_in;
      key_ff  <= key_in;
      stat_ff <= stat_in;
      pos_ff  <= pos_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/ordered_value_list_engine_top.sv
// Top level of the ordered value list engine: store, sequencer and result register.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit values in a
// dense store. A request transfer on the req_ channel carries an operation
// (append, search or delete first match) and a value; every request gives
// exactly one response transfer on the rsp_ channel with a status, the
// 1-based position involved and the entry count after the operation.
// A transfer happens at a clock edge where valid is high and stall is low.
// Requests are taken one at a time: req_stall is high from the cycle after
// a request is taken until its result has been moved into the response
// register. An append, an unused code, or a search or delete on an empty
// list goes straight to the done state and from there into the response
// register. Search and delete walk the list one entry per cycle through a
// single compare unit behind the registered store read, and delete then
// moves each later entry down one slot per cycle. A result waiting under
// rsp_stall holds the sequencer until it leaves. A synchronous reset
// empties the list and drops any pending response; store contents are
// not cleared.
`default_nettype none

module ordered_value_list_engine_top
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_position,
   output logic [4:0]              rsp_entry_count
);

   // The count must hold DEPTH itself; the address only DEPTH - 1.
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [31:0]   rd_data;
   logic          out_free;
   logic          res_load;
   result_type    res;

   logic          rsp_valid_ff;
   result_type    rsp_ff;

   // The response register can take a new result when it is empty or its
   // current result leaves at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   ovle_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   ovle_seq #(
      .DEPTH (DEPTH),
      .CW    (CW),
      .AW    (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (op_type'(req_operation)),
      .req_value (32'(req_value)),
      .out_free  (out_free),
      .res_load  (res_load),
      .res       (res),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   // Response register: loads a finished result, holds it while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_position    = rsp_ff.position;
   assign rsp_entry_count = rsp_ff.entry_count;

endmodule

`default_nettype wire

// File: verif/list_result_checker.sv
// Checker for the ordered value list engine: tracks the list and compares every response.
`timescale 1ns / 1ps

module list_result_checker
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_value,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [4:0]         rsp_position,
   input  wire logic [4:0]         rsp_entry_count,
   output int                      mismatch_count,
   output int                      outstanding
);

   // Shadow copy of the list, in list order at slots 0 .. list_len-1.
   logic [31:0] list_values [DEPTH];
   int          list_len;
   result_type  awaited_responses [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Applies one request to the shadow list and returns the response it must give.
   function automatic result_type apply_list_request(input logic [1:0] op,
                                                     input logic [31:0] key);
      result_type res;
      int         hit;
      res.status   = STAT_NOT_FOUND;
      res.position = '0;
      hit = -1;
      for (int i = 0; i < list_len; i++) begin
         if (hit < 0 && list_values[i] == key) hit = i;
      end
      case (op)
         OP_APPEND: begin
            if (list_len >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               list_values[list_len] = key;
               list_len++;
               res.status   = STAT_DONE;
               res.position = 5'(list_len);
            end
         end
         OP_SEARCH: begin
            if (hit >= 0) begin
               res.status   = STAT_DONE;
               res.position = 5'(hit + 1);
            end
         end
         OP_DELETE: begin
            if (list_len == 0) begin
               res.status = STAT_EMPTY;
            end else if (hit >= 0) begin
               for (int j = hit; j + 1 < list_len; j++) list_values[j] = list_values[j + 1];
               list_len--;
               res.status   = STAT_DONE;
               res.position = 5'(hit + 1);
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(list_len);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         list_len = 0;
         awaited_responses.delete();
      end else begin
         // A response never belongs to a request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: response transfer with no request waiting", $realtime);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_position !== want.position)
                  report_mismatch("position", rsp_position, want.position);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
            end
         end
         if (req_valid && !req_stall)
            awaited_responses.push_back(apply_list_request(req_operation, req_value));
      end
      outstanding = awaited_responses.size();
   end

endmodule

// File: verif/tb.sv
// Testbench top for the ordered value list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import ovle_pkg::*;

   localparam int DEPTH = 16;
   // CYCLE_LIMIT lies well above the slowest correct run, so only a hung
   // handshake ever reaches it.
   localparam int CYCLE_LIMIT = 300000;
   // Operation code 3 is not defined by the block; it must answer not found.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = OP_APPEND;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_position;
   logic [4:0]         rsp_entry_count;

   int mismatch_count;
   int outstanding;
   int cycle_count;

   // Idling rates in percent, changed between phases of the stimulus.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;

   // A few values that the random part draws from most of the time, so that
   // searches and deletes find matches and duplicates build up.
   logic [31:0] value_pool [8];

   ordered_value_list_engine_top #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_count(rsp_entry_count)
   );

   list_result_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_count(rsp_entry_count),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The watchdog: a run that hangs on a handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The response side stalls at random, decided once per cycle at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Presents one request and holds it until the transfer happens. Inputs
   // change only at falling edges; the stall is looked at on the rising edge,
   // before the block updates it, so the accept decision matches the block's.
   task automatic send_request(input logic [1:0] op, input logic [31:0] val);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Mostly pool values, sometimes any 32-bit pattern.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(99) < 75) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_operation(input int append_pct);
      int r;
      r = $urandom_range(99);
      if (r < 4) return OP_UNUSED;
      if (r < 4 + append_pct) return OP_APPEND;
      if (r < 4 + append_pct + (96 - append_pct) / 2) return OP_SEARCH;
      return OP_DELETE;
   endfunction

   initial begin
      logic [31:0] fill_values [DEPTH];
      int          append_pct;
      int          mode;

      fill_values[0] = 32'h8000_0000;
      fill_values[1] = 32'h7FFF_FFFF;
      fill_values[2] = 32'h0000_0000;
      fill_values[3] = 32'hFFFF_FFFF;
      fill_values[4] = 32'h0000_0001;
      fill_values[5] = 32'hFFFF_FFFF;
      fill_values[6] = 32'h5555_5555;
      fill_values[7] = 32'hAAAA_AAAA;
      for (int i = 8; i < DEPTH; i++) fill_values[i] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. On an empty list: search misses, delete reports
      // empty, and the unused code changes nothing.
      send_request(OP_SEARCH, 32'h0000_0007);
      send_request(OP_DELETE, 32'h0000_0007);
      send_request(OP_UNUSED, 32'h0000_0000);
      // Fill to the last slot with the extremes and a duplicate of -1.
      for (int i = 0; i < DEPTH; i++) send_request(OP_APPEND, fill_values[i]);
      // A full list refuses an append; the unused code still changes nothing.
      send_request(OP_APPEND, 32'h0000_002A);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      // The search must land on the first of the two equal entries.
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      // Deletes at the head, the tail and the middle, then misses.
      send_request(OP_DELETE, 32'h8000_0000);
      send_request(OP_DELETE, fill_values[DEPTH - 1]);
      send_request(OP_DELETE, 32'h5555_5555);
      send_request(OP_DELETE, 32'h1234_5678);
      send_request(OP_SEARCH, 32'h1234_5678);

      // Random part in five phases of idling: none, sender only, receiver
      // only, both lightly, then none again. The append share moves every
      // 25 items so the list keeps swinging between empty and full.
      for (int phase = 0; phase < 5; phase++) begin
         mode = phase % 4;
         sender_idle_pct    = (mode == 1) ? 57 : (mode == 3) ? 8 : 0;
         receiver_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 8 : 0;
         append_pct = 45;
         for (int i = 0; i < 100; i++) begin
            if (i % 25 == 0) begin
               case ($urandom_range(2))
                  0:       append_pct = 20;
                  1:       append_pct = 45;
                  default: append_pct = 75;
               endcase
            end
            send_request(pick_operation(append_pct), pick_value());
         end
      end

      req_valid <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait (outstanding == 0);
      // Leave room for a stray extra response to show up and be caught.
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
